/* hdl/ffha_pkg.sv */
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned ALIGN_W  = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_THR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_LOG2 = 2'd3;

   localparam logic [ADDR_W-1:0]  HEAP_END_RESET  = 48'hFFFF_FFFF_FFFF;
   localparam logic [SIZE_W-1:0]  SPLIT_THR_RESET = 32'd16;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET     = 4'd3;

   typedef struct packed {
      logic              operation;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   block_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_START,
      ST_A_SCAN,
      ST_A_TAKE,
      ST_A_PUSH,
      ST_A_BUMP,
      ST_POP,
      ST_POP_WAIT,
      ST_SPLIT_WR,
      ST_BUMP_WR,
      ST_R_SCAN,
      ST_R_TAKE,
      ST_I_START,
      ST_I_SCAN,
      ST_I_FIX,
      ST_M_START,
      ST_M_FIRST,
      ST_M_SCAN,
      ST_M_END,
      ST_FIN
   } state_type;

endpackage

/* hdl/first_fit_heap_allocator_top.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Beat
// req_      in         req_valid / req_ready  ffha_pkg::req_type (operation, size, address)
// rsp_      out        rsp_valid / rsp_ready  ffha_pkg::rsp_type (block address, status)
// csr_      in         csr_valid / csr_ready  csr_index, csr_data (register write)
//
// One request at a time, one node of a descriptor list per cycle through the single
// read port of the descriptor memory. Allocate takes the first fit in the free list or
// bumps the heap top; release unlinks its block from the used list. A split, or a release
// that found its block, inserts into the free list and merges runs. Reset is synchronous;
// the descriptor memory needs no clearing pass, list lengths and a fresh-descriptor count
// stand in for it. A result waiting on rsp_ready holds in the output register while the
// next request is taken; a finished request holds in its last state until that drains.

module first_fit_heap_allocator_top #(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ffha_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ffha_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ffha_pkg::ADDR_W-1:0]        csr_data
);

   localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned AW = ffha_pkg::ADDR_W;
   localparam int unsigned SW = ffha_pkg::SIZE_W;

   // descriptor memory: address, size and link words, one read port shared
   logic [AW-1:0] mem_addr [MAX_BLOCKS];
   logic [SW-1:0] mem_size [MAX_BLOCKS];
   logic [IW-1:0] mem_link [MAX_BLOCKS];

   logic          rd_en;
   logic [IW-1:0] rd_idx;
   logic [AW-1:0] rd_addr_q;
   logic [SW-1:0] rd_size_q;
   logic [IW-1:0] rd_link_q;

   logic          wa_en, ws_en, wl_en;
   logic [IW-1:0] wa_idx, ws_idx, wl_idx;
   logic [AW-1:0] wa_data;
   logic [SW-1:0] ws_data;
   logic [IW-1:0] wl_data;

   ffha_pkg::state_type state_ff, state_in;

   logic [SW:0]   num_ff, num_in;
   logic [AW-1:0] key_ff, key_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic          prev_vld_ff, prev_vld_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [AW-1:0] cur_addr_ff, cur_addr_in;
   logic [SW-1:0] cur_size_ff, cur_size_in;
   logic [IW-1:0] cur_link_ff, cur_link_in;
   logic          at_top_ff, at_top_in;
   logic [IW-1:0] new_ff, new_in;
   logic          bump_ff, bump_in;
   logic [IW-1:0] base_ff, base_in;
   logic [AW:0]   run_end_ff, run_end_in;
   logic [SW-1:0] run_len_ff, run_len_in;
   logic          ext_ff, ext_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [ffha_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   logic [AW-1:0] heap_top_ff, heap_top_in;
   logic [AW-1:0] heap_end_ff, heap_end_in;
   logic [SW-1:0] thr_ff, thr_in;
   logic [ffha_pkg::ALIGN_W-1:0] align_ff, align_in;

   logic [IW-1:0] free_head_ff, free_head_in;
   logic [IW-1:0] used_head_ff, used_head_in;
   logic [IW-1:0] spare_head_ff, spare_head_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [CW-1:0] used_cnt_ff, used_cnt_in;
   logic [CW-1:0] spare_cnt_ff, spare_cnt_in;
   logic [CW-1:0] fresh_ff, fresh_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_type rsp_ff, rsp_in;

   // shared conditions
   logic [SW:0]   low_mask;
   logic [SW:0]   num_round;
   logic [SW-1:0] num_lo;
   logic [AW:0]   node_end;
   logic          node_at_top;
   logic          node_hit;
   logic          is_last;
   logic          spare_avail;
   logic [SW-1:0] excess;
   logic          split_ok;
   logic [AW:0]   bump_end;
   logic          bump_fit;
   logic [SW:0]   len_sum;
   logic          absorb;
   logic          rsp_free;

   assign low_mask  = (SW+1)'(((SW+1)'(1) << align_ff) - (SW+1)'(1));
   assign num_round = ({1'b0, req_payload.request_size} + low_mask) & ~low_mask;
   assign num_lo    = num_ff[SW-1:0];
   assign node_end  = {1'b0, rd_addr_q} + {{(AW+1-SW){1'b0}}, rd_size_q};
   assign node_at_top = (node_end >= {1'b0, heap_top_ff})
                     && (({1'b0, rd_addr_q} + {{(AW+1-SW){1'b0}}, num_lo})
                         <= {1'b0, heap_end_ff});
   assign node_hit  = node_at_top || (rd_size_q >= num_lo);
   assign is_last   = (rem_ff == CW'(1));
   assign spare_avail = (spare_cnt_ff != '0) || (fresh_ff < CW'(MAX_BLOCKS));
   assign excess    = cur_size_ff - num_lo;
   assign split_ok  = spare_avail && (excess >= thr_ff);
   assign bump_end  = {1'b0, heap_top_ff} + {{(AW+1-SW){1'b0}}, num_lo};
   assign bump_fit  = spare_avail && (bump_end <= {1'b0, heap_end_ff});
   assign len_sum   = {1'b0, run_len_ff} + {1'b0, rd_size_q};
   assign absorb    = (run_end_ff == {1'b0, rd_addr_q}) && !len_sum[SW];
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready   = (state_ff == ffha_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.operation == ffha_pkg::OP_ALLOC) begin
                  state_in = ffha_pkg::ST_A_START;
               end else if (used_cnt_ff == '0) begin
                  state_in = ffha_pkg::ST_FIN;
               end else begin
                  state_in = ffha_pkg::ST_R_SCAN;
               end
            end
         end
         ffha_pkg::ST_A_START: begin
            priority if (num_ff[SW])        state_in = ffha_pkg::ST_FIN;
            else if (free_cnt_ff == '0)     state_in = ffha_pkg::ST_A_BUMP;
            else                            state_in = ffha_pkg::ST_A_SCAN;
         end
         ffha_pkg::ST_A_SCAN: begin
            priority if (node_hit) state_in = ffha_pkg::ST_A_TAKE;
            else if (is_last)      state_in = ffha_pkg::ST_A_BUMP;
         end
         ffha_pkg::ST_A_TAKE: state_in = ffha_pkg::ST_A_PUSH;
         ffha_pkg::ST_A_PUSH: begin
            if (!at_top_ff && split_ok) state_in = ffha_pkg::ST_POP;
            else                        state_in = ffha_pkg::ST_FIN;
         end
         ffha_pkg::ST_A_BUMP: begin
            state_in = bump_fit ? ffha_pkg::ST_POP : ffha_pkg::ST_FIN;
         end
         ffha_pkg::ST_POP: begin
            if (spare_cnt_ff != '0) state_in = ffha_pkg::ST_POP_WAIT;
            else state_in = bump_ff ? ffha_pkg::ST_BUMP_WR : ffha_pkg::ST_SPLIT_WR;
         end
         ffha_pkg::ST_POP_WAIT: begin
            state_in = bump_ff ? ffha_pkg::ST_BUMP_WR : ffha_pkg::ST_SPLIT_WR;
         end
         ffha_pkg::ST_SPLIT_WR: state_in = ffha_pkg::ST_I_START;
         ffha_pkg::ST_BUMP_WR:  state_in = ffha_pkg::ST_FIN;
         ffha_pkg::ST_R_SCAN: begin
            priority if (rd_addr_q == key_ff) state_in = ffha_pkg::ST_R_TAKE;
            else if (is_last)                 state_in = ffha_pkg::ST_FIN;
         end
         ffha_pkg::ST_R_TAKE: state_in = ffha_pkg::ST_I_START;
         ffha_pkg::ST_I_START: begin
            state_in = (free_cnt_ff == '0) ? ffha_pkg::ST_M_START : ffha_pkg::ST_I_SCAN;
         end
         ffha_pkg::ST_I_SCAN: begin
            priority if (key_ff <= rd_addr_q) begin
               state_in = prev_vld_ff ? ffha_pkg::ST_I_FIX : ffha_pkg::ST_M_START;
            end else if (is_last) begin
               state_in = ffha_pkg::ST_M_START;
            end
         end
         ffha_pkg::ST_I_FIX:   state_in = ffha_pkg::ST_M_START;
         ffha_pkg::ST_M_START: state_in = ffha_pkg::ST_M_FIRST;
         ffha_pkg::ST_M_FIRST: begin
            state_in = is_last ? ffha_pkg::ST_M_END : ffha_pkg::ST_M_SCAN;
         end
         ffha_pkg::ST_M_SCAN: begin
            if (is_last) state_in = ffha_pkg::ST_M_END;
         end
         ffha_pkg::ST_M_END: state_in = ffha_pkg::ST_FIN;
         ffha_pkg::ST_FIN: begin
            if (rsp_free) state_in = ffha_pkg::ST_IDLE;
         end
         default: state_in = ffha_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      num_in        = num_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      prev_in       = prev_ff;
      prev_vld_in   = prev_vld_ff;
      rem_in        = rem_ff;
      cur_addr_in   = cur_addr_ff;
      cur_size_in   = cur_size_ff;
      cur_link_in   = cur_link_ff;
      at_top_in     = at_top_ff;
      new_in        = new_ff;
      bump_in       = bump_ff;
      base_in       = base_ff;
      run_end_in    = run_end_ff;
      run_len_in    = run_len_ff;
      ext_in        = ext_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      heap_top_in   = heap_top_ff;
      heap_end_in   = heap_end_ff;
      thr_in        = thr_ff;
      align_in      = align_ff;
      free_head_in  = free_head_ff;
      used_head_in  = used_head_ff;
      spare_head_in = spare_head_ff;
      free_cnt_in   = free_cnt_ff;
      used_cnt_in   = used_cnt_ff;
      spare_cnt_in  = spare_cnt_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rd_en   = 1'b0;
      rd_idx  = rd_link_q;
      wa_en   = 1'b0;
      wa_idx  = new_ff;
      wa_data = key_ff;
      ws_en   = 1'b0;
      ws_idx  = ptr_ff;
      ws_data = num_lo;
      wl_en   = 1'b0;
      wl_idx  = ptr_ff;
      wl_data = used_head_ff;

      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            if (req_valid) begin
               num_in        = num_round;
               key_in        = req_payload.release_address;
               prev_vld_in   = 1'b0;
               res_addr_in   = '0;
               res_status_in = ffha_pkg::STATUS_NOT_USED;
               if (req_payload.operation == ffha_pkg::OP_RELEASE) begin
                  rd_en  = 1'b1;
                  rd_idx = used_head_ff;
                  ptr_in = used_head_ff;
                  rem_in = used_cnt_ff;
               end
            end
         end
         ffha_pkg::ST_A_START: begin
            res_status_in = ffha_pkg::STATUS_NO_SPACE;
            if (!num_ff[SW] && (free_cnt_ff != '0)) begin
               rd_en  = 1'b1;
               rd_idx = free_head_ff;
               ptr_in = free_head_ff;
               rem_in = free_cnt_ff;
            end
         end
         ffha_pkg::ST_A_SCAN: begin
            if (node_hit) begin
               cur_addr_in = rd_addr_q;
               cur_size_in = rd_size_q;
               cur_link_in = rd_link_q;
               at_top_in   = node_at_top;
            end else begin
               prev_in     = ptr_ff;
               prev_vld_in = 1'b1;
               if (!is_last) begin
                  rem_in = rem_ff - CW'(1);
                  rd_en  = 1'b1;
                  ptr_in = rd_link_q;
               end
            end
         end
         ffha_pkg::ST_A_TAKE: begin
            // unlink the chosen block from the free list
            if (prev_vld_ff) begin
               wl_en   = 1'b1;
               wl_idx  = prev_ff;
               wl_data = cur_link_ff;
            end else begin
               free_head_in = cur_link_ff;
            end
            free_cnt_in = free_cnt_ff - CW'(1);
         end
         ffha_pkg::ST_A_PUSH: begin
            wl_en         = 1'b1;
            used_head_in  = ptr_ff;
            used_cnt_in   = used_cnt_ff + CW'(1);
            res_addr_in   = cur_addr_ff;
            res_status_in = ffha_pkg::STATUS_OK;
            if (at_top_ff) begin
               ws_en       = 1'b1;
               heap_top_in = cur_addr_ff + AW'(num_lo);
            end else if (split_ok) begin
               ws_en       = 1'b1;
               key_in      = cur_addr_ff + AW'(num_lo);
               cur_size_in = excess;
               bump_in     = 1'b0;
            end
         end
         ffha_pkg::ST_A_BUMP: begin
            bump_in = 1'b1;
         end
         ffha_pkg::ST_POP: begin
            if (spare_cnt_ff != '0) begin
               new_in = spare_head_ff;
               rd_en  = 1'b1;
               rd_idx = spare_head_ff;
            end else begin
               new_in   = fresh_ff[IW-1:0];
               fresh_in = fresh_ff + CW'(1);
            end
         end
         ffha_pkg::ST_POP_WAIT: begin
            spare_head_in = rd_link_q;
            spare_cnt_in  = spare_cnt_ff - CW'(1);
         end
         ffha_pkg::ST_SPLIT_WR: begin
            wa_en   = 1'b1;
            ws_en   = 1'b1;
            ws_idx  = new_ff;
            ws_data = cur_size_ff;
         end
         ffha_pkg::ST_BUMP_WR: begin
            wa_en         = 1'b1;
            wa_data       = heap_top_ff;
            ws_en         = 1'b1;
            ws_idx        = new_ff;
            wl_en         = 1'b1;
            wl_idx        = new_ff;
            used_head_in  = new_ff;
            used_cnt_in   = used_cnt_ff + CW'(1);
            heap_top_in   = bump_end[AW-1:0];
            res_addr_in   = heap_top_ff;
            res_status_in = ffha_pkg::STATUS_OK;
         end
         ffha_pkg::ST_R_SCAN: begin
            if (rd_addr_q == key_ff) begin
               cur_link_in = rd_link_q;
               new_in      = ptr_ff;
            end else begin
               prev_in     = ptr_ff;
               prev_vld_in = 1'b1;
               if (!is_last) begin
                  rem_in = rem_ff - CW'(1);
                  rd_en  = 1'b1;
                  ptr_in = rd_link_q;
               end
            end
         end
         ffha_pkg::ST_R_TAKE: begin
            if (prev_vld_ff) begin
               wl_en   = 1'b1;
               wl_idx  = prev_ff;
               wl_data = cur_link_ff;
            end else begin
               used_head_in = cur_link_ff;
            end
            used_cnt_in   = used_cnt_ff - CW'(1);
            res_addr_in   = '0;
            res_status_in = ffha_pkg::STATUS_OK;
         end
         ffha_pkg::ST_I_START: begin
            prev_vld_in = 1'b0;
            if (free_cnt_ff == '0) begin
               free_head_in = new_ff;
               free_cnt_in  = CW'(1);
            end else begin
               rd_en  = 1'b1;
               rd_idx = free_head_ff;
               ptr_in = free_head_ff;
               rem_in = free_cnt_ff;
            end
         end
         ffha_pkg::ST_I_SCAN: begin
            if (key_ff <= rd_addr_q) begin
               // insert ahead of the current node
               wl_en       = 1'b1;
               wl_idx      = new_ff;
               wl_data     = ptr_ff;
               free_cnt_in = free_cnt_ff + CW'(1);
               if (!prev_vld_ff) begin
                  free_head_in = new_ff;
               end
            end else if (is_last) begin
               wl_en       = 1'b1;
               wl_data     = new_ff;
               free_cnt_in = free_cnt_ff + CW'(1);
            end else begin
               prev_in     = ptr_ff;
               prev_vld_in = 1'b1;
               rem_in      = rem_ff - CW'(1);
               rd_en       = 1'b1;
               ptr_in      = rd_link_q;
            end
         end
         ffha_pkg::ST_I_FIX: begin
            wl_en   = 1'b1;
            wl_idx  = prev_ff;
            wl_data = new_ff;
         end
         ffha_pkg::ST_M_START: begin
            rd_en  = 1'b1;
            rd_idx = free_head_ff;
            ptr_in = free_head_ff;
            rem_in = free_cnt_ff;
         end
         ffha_pkg::ST_M_FIRST: begin
            base_in    = ptr_ff;
            run_end_in = node_end;
            run_len_in = rd_size_q;
            ext_in     = 1'b0;
            if (!is_last) begin
               rem_in = rem_ff - CW'(1);
               rd_en  = 1'b1;
               ptr_in = rd_link_q;
            end
         end
         ffha_pkg::ST_M_SCAN: begin
            if (absorb) begin
               // fold the node into the run and return its descriptor
               wl_en         = 1'b1;
               wl_data       = spare_head_ff;
               spare_head_in = ptr_ff;
               spare_cnt_in  = spare_cnt_ff + CW'(1);
               free_cnt_in   = free_cnt_ff - CW'(1);
               run_end_in    = node_end;
               run_len_in    = len_sum[SW-1:0];
               ext_in        = 1'b1;
            end else begin
               if (ext_ff) begin
                  ws_en   = 1'b1;
                  ws_idx  = base_ff;
                  ws_data = run_len_ff;
                  wl_en   = 1'b1;
                  wl_idx  = base_ff;
                  wl_data = ptr_ff;
               end
               base_in    = ptr_ff;
               run_end_in = node_end;
               run_len_in = rd_size_q;
               ext_in     = 1'b0;
            end
            if (!is_last) begin
               rem_in = rem_ff - CW'(1);
               rd_en  = 1'b1;
               ptr_in = rd_link_q;
            end
         end
         ffha_pkg::ST_M_END: begin
            if (ext_ff) begin
               ws_en   = 1'b1;
               ws_idx  = base_ff;
               ws_data = run_len_ff;
            end
         end
         ffha_pkg::ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.block_address = res_addr_ff;
               rsp_in.status        = res_status_ff;
            end
         end
         default: begin
         end
      endcase

      // register writes are to arrive only while idle; the block itself does not enforce this
      if (csr_valid) begin
         unique case (csr_index)
            ffha_pkg::CSR_HEAP_START: heap_top_in = csr_data;
            ffha_pkg::CSR_HEAP_END:   heap_end_in = csr_data;
            ffha_pkg::CSR_SPLIT_THR:  thr_in      = csr_data[SW-1:0];
            ffha_pkg::CSR_ALIGN_LOG2: align_in    = csr_data[ffha_pkg::ALIGN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // descriptor memory, write-first on a same-entry read
   always_ff @(posedge clock) begin
      if (wa_en) begin
         mem_addr[wa_idx] <= wa_data;
      end
      if (rd_en) begin
         rd_addr_q <= (wa_en && (wa_idx == rd_idx)) ? wa_data : mem_addr[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (ws_en) begin
         mem_size[ws_idx] <= ws_data;
      end
      if (rd_en) begin
         rd_size_q <= (ws_en && (ws_idx == rd_idx)) ? ws_data : mem_size[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wl_en) begin
         mem_link[wl_idx] <= wl_data;
      end
      if (rd_en) begin
         rd_link_q <= (wl_en && (wl_idx == rd_idx)) ? wl_data : mem_link[rd_idx];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_IDLE;
         heap_top_ff  <= '0;
         heap_end_ff  <= ffha_pkg::HEAP_END_RESET;
         thr_ff       <= ffha_pkg::SPLIT_THR_RESET;
         align_ff     <= ffha_pkg::ALIGN_RESET;
         free_cnt_ff  <= '0;
         used_cnt_ff  <= '0;
         spare_cnt_ff <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_top_ff  <= heap_top_in;
         heap_end_ff  <= heap_end_in;
         thr_ff       <= thr_in;
         align_ff     <= align_in;
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         spare_cnt_ff <= spare_cnt_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      prev_ff       <= prev_in;
      prev_vld_ff   <= prev_vld_in;
      rem_ff        <= rem_in;
      cur_addr_ff   <= cur_addr_in;
      cur_size_ff   <= cur_size_in;
      cur_link_ff   <= cur_link_in;
      at_top_ff     <= at_top_in;
      new_ff        <= new_in;
      bump_ff       <= bump_in;
      base_ff       <= base_in;
      run_end_ff    <= run_end_in;
      run_len_ff    <= run_len_in;
      ext_ff        <= ext_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      free_head_ff  <= free_head_in;
      used_head_ff  <= used_head_in;
      spare_head_ff <= spare_head_in;
      rsp_ff        <= rsp_in;
   end

endmodule
